/* rtl/rrb_pkg.sv */
// rrb_pkg: shared constants, types and codes for the rotating rgb565 blitter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rrb_pkg;

  // largest frame the counters cover
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // counter widths and clamped dimension widths
  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
  localparam int unsigned W_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AB_W  = (COL_W > ROW_W) ? COL_W : ROW_W;

  // register field widths
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned PITCH_W = 13;
  localparam int unsigned CLAMP_W = (DIM_W > W_W) ? ((DIM_W > H_W) ? DIM_W : H_W)
                                                  : ((W_W > H_W) ? W_W : H_W);

  // apb port
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // payload widths
  localparam int unsigned CH_W   = 8;
  localparam int unsigned PIX_W  = 16;
  localparam int unsigned OFF_W  = 23;
  localparam int unsigned PROD_W = AB_W + 1 + PITCH_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  // job queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // reset values of the registers
  localparam logic [MODE_W-1:0]         RST_MODE    = MODE_W'(1);
  localparam logic [DIM_W-1:0]          RST_WIDTH   = DIM_W'(320);
  localparam logic [DIM_W-1:0]          RST_HEIGHT  = DIM_W'(240);
  localparam logic signed [PITCH_W-1:0] RST_X_PITCH = PITCH_W'(2);
  localparam logic signed [PITCH_W-1:0] RST_Y_PITCH = PITCH_W'(480);

  typedef enum logic [MODE_W-1:0] {
    MODE_FLIP_PORTRAIT  = 2'd0,
    MODE_LANDSCAPE      = 2'd1,
    MODE_FLIP_LANDSCAPE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_WIDTH   = 3'd1,
    REG_HEIGHT  = 3'd2,
    REG_X_PITCH = 3'd3,
    REG_Y_PITCH = 3'd4
  } reg_idx_e;

  // effective configuration as seen by front and back
  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [W_W-1:0]            width;
    logic [H_W-1:0]            height;
    logic signed [PITCH_W-1:0] x_pitch;
    logic signed [PITCH_W-1:0] y_pitch;
  } cfg_t;

  // one classified pixel waiting for address arithmetic
  typedef struct packed {
    logic [AB_W-1:0]  a;
    logic [AB_W-1:0]  b;
    logic [PIX_W-1:0] pix;
    logic             last;
  } job_t;

endpackage

/* rtl/rotating_rgb565_blitter.sv */
// rotating_rgb565_blitter: top level of the rgb888 to rgb565 rotating blitter
// depends on rrb_pkg, rrb_cfg, rrb_front, rrb_fifo and rrb_back
`timescale 1ns / 1ps

// usage
//   source pixels (blue, green, red bytes plus frame_start) arrive on a
//   valid/ready input channel in buffer order; each transaction yields one
//   result transaction carrying the packed rgb565 word, the signed framebuffer
//   offset in 16-bit words and a flag on the last pixel of the frame
//   the apb port holds rotation mode, frame width and height and the two
//   signed pitches; write it only while no transaction is in flight
//   an accepted pixel passes the queue, the product register and the output
//   register in that order before it is presented
//   throughput: one pixel per clock unless stalled, set by the single multiplier
//   pair in the back stage; the front takes a pixel every cycle the queue has room
//   reset clears the row and column counters, empties the queue and loads
//   landscape mode, 320 by 240, x pitch 2 and y pitch 480
//   when the receiver stalls the output register holds its transaction, the
//   product stage and the two-entry queue fill, then in_ready_o drops
//   frame_start restarts the walk at the first pixel of a frame

module rotating_rgb565_blitter import rrb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  // source pixels
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CH_W-1:0]         blue_i,
  input  logic [CH_W-1:0]         green_i,
  input  logic [CH_W-1:0]         red_i,
  input  logic                    frame_start_i,
  // placed pixels
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OFF_W-1:0] word_offset_o,
  output logic [PIX_W-1:0]        pixel565_o,
  output logic                    frame_last_o
);

  cfg_t cfg;
  job_t push_job, pop_job;
  logic push, pop, q_full, q_valid;

  // register file, dimensions already clamped
  rrb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // front: counters and rotation mapping, one job per accepted pixel
  rrb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .blue_i        (blue_i),
    .green_i       (green_i),
    .red_i         (red_i),
    .frame_start_i (frame_start_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .job_o         (push_job)
  );

  // queue lets the front keep accepting while the back is stalled briefly
  rrb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_job)
  );

  // back: pitch products, halving and offset sum into the output register
  rrb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_valid_i     (q_valid),
    .job_i         (pop_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .word_offset_o (word_offset_o),
    .pixel565_o    (pixel565_o),
    .frame_last_o  (frame_last_o)
  );

endmodule

/* rtl/rrb_cfg.sv */
// rrb_cfg: apb register file with mode, frame size and pitches
// depends on rrb_pkg; presents clamped dimensions to the datapath
`timescale 1ns / 1ps

module rrb_cfg import rrb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [MODE_W-1:0]         mode_q,    mode_d;
  logic [DIM_W-1:0]          width_q,   width_d;
  logic [DIM_W-1:0]          height_q,  height_d;
  logic signed [PITCH_W-1:0] x_pitch_q, x_pitch_d;
  logic signed [PITCH_W-1:0] y_pitch_q, y_pitch_d;
  logic                      wr_en;
  reg_idx_e                  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_comb begin
    mode_d    = mode_q;
    width_d   = width_q;
    height_d  = height_q;
    x_pitch_d = x_pitch_q;
    y_pitch_d = y_pitch_q;
    if (wr_en) begin
      unique case (idx)
        REG_MODE:    mode_d    = pwdata[MODE_W-1:0];
        REG_WIDTH:   width_d   = pwdata[DIM_W-1:0];
        REG_HEIGHT:  height_d  = pwdata[DIM_W-1:0];
        REG_X_PITCH: x_pitch_d = pwdata[PITCH_W-1:0];
        REG_Y_PITCH: y_pitch_d = pwdata[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= RST_MODE;
      width_q   <= RST_WIDTH;
      height_q  <= RST_HEIGHT;
      x_pitch_q <= RST_X_PITCH;
      y_pitch_q <= RST_Y_PITCH;
    end else begin
      mode_q    <= mode_d;
      width_q   <= width_d;
      height_q  <= height_d;
      x_pitch_q <= x_pitch_d;
      y_pitch_q <= y_pitch_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MODE:    prdata = DATA_W'(mode_q);
      REG_WIDTH:   prdata = DATA_W'(width_q);
      REG_HEIGHT:  prdata = DATA_W'(height_q);
      REG_X_PITCH: prdata = DATA_W'(unsigned'(x_pitch_q));
      REG_Y_PITCH: prdata = DATA_W'(unsigned'(y_pitch_q));
      default:     prdata = '0;
    endcase
  end

  // zero counts as one, oversize saturates
  always_comb begin
    cfg_o.mode    = mode_q;
    cfg_o.x_pitch = x_pitch_q;
    cfg_o.y_pitch = y_pitch_q;
    if (width_q == '0) begin
      cfg_o.width = W_W'(1);
    end else if (CLAMP_W'(width_q) > CLAMP_W'(MAX_WIDTH)) begin
      cfg_o.width = W_W'(MAX_WIDTH);
    end else begin
      cfg_o.width = W_W'(width_q);
    end
    if (height_q == '0) begin
      cfg_o.height = H_W'(1);
    end else if (CLAMP_W'(height_q) > CLAMP_W'(MAX_HEIGHT)) begin
      cfg_o.height = H_W'(MAX_HEIGHT);
    end else begin
      cfg_o.height = H_W'(height_q);
    end
  end

endmodule

/* rtl/rrb_front.sv */
// rrb_front: accepts source pixels, walks row and column, maps them by rotation
// depends on rrb_pkg; pushes one job per pixel into the queue
`timescale 1ns / 1ps

module rrb_front import rrb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [CH_W-1:0] blue_i,
  input  logic [CH_W-1:0] green_i,
  input  logic [CH_W-1:0] red_i,
  input  logic            frame_start_i,
  input  logic            q_full_i,
  output logic            push_o,
  output job_t            job_o
);

  logic [COL_W-1:0] col_q, col_d, col_cur, w_m1;
  logic [ROW_W-1:0] row_q, row_d, row_cur, h_m1;
  logic [W_W-1:0]   col_inc;
  logic [H_W-1:0]   row_inc;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign w_m1       = COL_W'(cfg_i.width - W_W'(1));
  assign h_m1       = ROW_W'(cfg_i.height - H_W'(1));

  always_comb begin
    col_cur = frame_start_i ? '0 : col_q;
    row_cur = frame_start_i ? '0 : row_q;
    // counters left beyond a shrunk frame restart at zero
    if (W_W'(col_cur) >= cfg_i.width) col_cur = '0;
    if (H_W'(row_cur) >= cfg_i.height) row_cur = '0;

    col_inc = W_W'(col_cur) + W_W'(1);
    row_inc = H_W'(row_cur) + H_W'(1);
    col_d   = COL_W'(col_inc);
    row_d   = row_cur;
    if (col_inc >= cfg_i.width) begin
      col_d = '0;
      row_d = (row_inc >= cfg_i.height) ? '0 : ROW_W'(row_inc);
    end
  end

  always_comb begin
    unique case (cfg_i.mode)
      MODE_FLIP_PORTRAIT: begin
        job_o.a = AB_W'(w_m1 - col_cur);
        job_o.b = AB_W'(row_cur);
      end
      MODE_LANDSCAPE: begin
        job_o.a = AB_W'(row_cur);
        job_o.b = AB_W'(col_cur);
      end
      default: begin
        job_o.a = AB_W'(h_m1 - row_cur);
        job_o.b = AB_W'(w_m1 - col_cur);
      end
    endcase
    job_o.pix  = {red_i[7:3], green_i[7:2], blue_i[7:3]};
    job_o.last = (row_cur == h_m1) && (col_cur == w_m1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (push_o) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && job_o.last) |=> (col_q == '0 && row_q == '0))
    else $error("counters did not wrap after last pixel");

endmodule

/* rtl/rrb_fifo.sv */
// rrb_fifo: short job queue parting the front from the back
// depends on rrb_pkg for the job type and depth
`timescale 1ns / 1ps

module rrb_fifo import rrb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  job_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == FCNT_W'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) count_d = count_q + FCNT_W'(1);
    else if (pop_i && !push_i) count_d = count_q - FCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full job queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("pop from empty job queue");

endmodule

/* rtl/rrb_back.sv */
// rrb_back: multiplies display coordinates by the pitches and sums the offset
// depends on rrb_pkg; two register stages, output stage faces the receiver
`timescale 1ns / 1ps

module rrb_back import rrb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    q_valid_i,
  input  job_t                    job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OFF_W-1:0] word_offset_o,
  output logic [PIX_W-1:0]        pixel565_o,
  output logic                    frame_last_o
);

  logic                     p_valid_q, p_ready;
  logic signed [PROD_W-1:0] prod_x_q, prod_x_d, prod_y_q, prod_y_d;
  logic [PIX_W-1:0]         p_pix_q;
  logic                     p_last_q;
  logic signed [AB_W:0]     a_s, b_s;
  logic                     o_valid_q, o_ready;
  logic signed [SUM_W-1:0]  sum;
  logic signed [OFF_W-1:0]  offset_q;
  logic [PIX_W-1:0]         o_pix_q;
  logic                     o_last_q;

  assign o_ready = !o_valid_q || out_ready_i;
  assign p_ready = !p_valid_q || o_ready;
  assign pop_o   = q_valid_i && p_ready;

  assign a_s      = {1'b0, job_i.a};
  assign b_s      = {1'b0, job_i.b};
  assign prod_x_d = PROD_W'(a_s) * PROD_W'(cfg_i.x_pitch);
  assign prod_y_d = PROD_W'(b_s) * PROD_W'(cfg_i.y_pitch);

  // halving with an arithmetic shift rounds towards minus infinity
  assign sum = SUM_W'(prod_x_q >>> 1) + SUM_W'(prod_y_q >>> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (p_ready) p_valid_q <= q_valid_i;
      if (o_ready) o_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      p_pix_q  <= job_i.pix;
      p_last_q <= job_i.last;
    end
    if (o_ready && p_valid_q) begin
      offset_q <= OFF_W'(sum);
      o_pix_q  <= p_pix_q;
      o_last_q <= p_last_q;
    end
  end

  assign out_valid_o   = o_valid_q;
  assign word_offset_o = offset_q;
  assign pixel565_o    = o_pix_q;
  assign frame_last_o  = o_last_q;

  a_prod_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && !o_ready) |=> (p_valid_q && $stable(prod_x_q) && $stable(prod_y_q)))
    else $error("product stage lost its transaction under stall");

endmodule
